@@ rtl/assert_macros.svh @@
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/i2cra_pkg.sv @@
`default_nettype none

package i2cra_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int DLY_W      = 10;
  localparam int MSB        = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_SCALE  = 1'b1;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [7:0] TICK_SCALE_RESET  = 8'd1;
  localparam logic [3:0] BYTE_BITS         = 4'd8;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_ADDR,
    ERR_DATA
  } err_t;

  typedef enum logic [1:0] {
    STG_ADDR,
    STG_REG,
    STG_LAST
  } stage_t;

  typedef enum logic [1:0] {
    SDA_REL,
    SDA_LOW,
    SDA_DATA
  } sda_ctl_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_BIT_SETUP,
    PH_BIT_HIGH,
    PH_BIT_LOW,
    PH_ACK_SETUP,
    PH_ACK_HIGH,
    PH_ACK_POLL,
    PH_RD_LOW,
    PH_RD_HIGH,
    PH_NACK_LOW,
    PH_NACK_HIGH,
    PH_STOP_A,
    PH_STOP_B,
    PH_FINISH
  } phase_t;

  typedef struct packed {
    logic       go;
    logic       mode;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    err_t       error_code;
  } res_t;

  // delay units of each bus phase
  function automatic logic [2:0] seg_units(input phase_t ph);
    logic [2:0] u;
    case (ph)
      PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B:          u = 3'd4;
      PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW, PH_RD_LOW,
      PH_NACK_LOW, PH_NACK_HIGH:                              u = 3'd2;
      PH_ACK_SETUP, PH_ACK_HIGH, PH_RD_HIGH:                  u = 3'd1;
      default:                                                u = 3'd0;
    endcase
    return u;
  endfunction

  function automatic logic seg_scl(input phase_t ph);
    logic s;
    case (ph)
      PH_BIT_SETUP, PH_BIT_LOW, PH_ACK_SETUP, PH_RD_LOW,
      PH_NACK_LOW, PH_STOP_A:                                 s = 1'b0;
      default:                                                s = 1'b1;
    endcase
    return s;
  endfunction

  function automatic sda_ctl_t seg_sda(input phase_t ph);
    sda_ctl_t c;
    case (ph)
      PH_START_B, PH_STOP_A, PH_STOP_B:                       c = SDA_LOW;
      PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW:                  c = SDA_DATA;
      default:                                                c = SDA_REL;
    endcase
    return c;
  endfunction

  function automatic logic [DLY_W-1:0] dly_load(input phase_t ph, input logic [7:0] scale);
    return DLY_W'(seg_units(ph)) * DLY_W'(scale);
  endfunction

endpackage

`default_nettype wire

@@ rtl/i2cra_in_if.sv @@
`default_nettype none

interface i2cra_in_if;
  logic       valid;
  logic       ready;
  logic       go;
  logic       mode;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic [7:0] wdata;
  logic       sda_in;

  modport source (output valid, go, mode, dev_addr, reg_addr, wdata, sda_in, input ready);
  modport sink   (input valid, go, mode, dev_addr, reg_addr, wdata, sda_in, output ready);
endinterface

`default_nettype wire

@@ rtl/i2cra_out_if.sv @@
`default_nettype none

interface i2cra_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic [1:0] error_code;

  modport source (output valid, scl_level, sda_drive_low, busy_res, done_res, read_byte,
                  error_code, input ready);
  modport sink   (input valid, scl_level, sda_drive_low, busy_res, done_res, read_byte,
                  error_code, output ready);
endinterface

`default_nettype wire

@@ rtl/i2c_register_access_master.sv @@
`default_nettype none
`include "assert_macros.svh"

// I2C master for single-register write and read transactions, advanced one bus tick per
// input word. Every accepted word gives exactly one result word with the SCL level, the
// SDA pull-down, busy, done, the read byte and the error code. The block takes one word
// per clock and gives one word per clock while out_ch.ready is high; an accepted word
// goes through the input queue into the result register. The queue holds QueueDepth
// words and its fill level alone sets in_ch.ready; the sequencer advances one tick for
// every result word that the output register can take. The user must write ack_timeout
// and tick_scale through the cfg_ port only while no word is in flight; the block does not enforce it.
module i2c_register_access_master #(
  parameter int QueueDepth = i2cra_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  i2cra_in_if.sink                          in_ch,
  i2cra_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [i2cra_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [i2cra_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import i2cra_pkg::*;

  q_word_t q_word;
  logic    q_ready;

  i2cra_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_word  (q_word),
    .q_ready (q_ready)
  );

  i2cra_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .q_word    (q_word),
    .q_ready   (q_ready),
    .out_ch    (out_ch)
  );

  `AST_IMP(a_err_only_on_done, out_ch.valid && (out_ch.error_code != ERR_NONE), out_ch.done_res)
  `AST_IMP(a_rdata_only_on_done, out_ch.valid && (out_ch.read_byte != 8'd0), out_ch.done_res)
  `AST_NXT(a_pop_fills_out, q_word.valid && q_ready, out_ch.valid)
  `AST_NXT(a_push_fills_queue, in_ch.valid && in_ch.ready, q_word.valid)

endmodule

`default_nettype wire

@@ rtl/i2cra_front.sv @@
`default_nettype none

module i2cra_front #(
  parameter int Depth = i2cra_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  i2cra_in_if.sink            in_ch,
  output i2cra_pkg::q_word_t  q_word,
  input  logic                q_ready
);
  import i2cra_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  item_t            mem_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             push, pop;
  item_t            in_item;

  assign in_item = '{go: in_ch.go, mode: in_ch.mode, dev_addr: in_ch.dev_addr,
                     reg_addr: in_ch.reg_addr, wdata: in_ch.wdata, sda_in: in_ch.sda_in};

  assign in_ch.ready  = (cnt_r != CntW'(Depth));
  assign q_word.valid = (cnt_r != '0);
  assign q_word.item  = mem_r[rd_ptr_r];

  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_word.valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/i2cra_back.sv @@
`default_nettype none

module i2cra_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [i2cra_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [i2cra_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  i2cra_pkg::q_word_t                    q_word,
  output logic                                  q_ready,
  i2cra_out_if.source                           out_ch
);
  import i2cra_pkg::*;

  logic [7:0]       ack_to_r, scale_r, scale_eff;
  phase_t           phase_r, phase_nxt, e_phase, ent_ph;
  logic [DLY_W-1:0] dc_r, dc_nxt, e_dc, dc_dec;
  logic [7:0]       wt_r, wt_nxt, e_wt;
  logic [3:0]       bc_r, bc_nxt, e_bc, bc_inc;
  logic [7:0]       sh_r, sh_nxt, e_sh;
  stage_t           st_r, st_nxt, e_st;
  err_t             err_r, err_nxt, e_err;
  logic             mode_r, e_mode;
  logic [6:0]       dev_r, e_dev;
  logic [7:0]       reg_r, e_reg;
  logic [7:0]       wdat_r, e_wdat;
  logic             start, pop;
  logic             do_enter, seg_done, ack_done, ack_tmo;
  sda_ctl_t         sda_ctl;
  res_t             res_nxt, res_r;
  logic             out_valid_r;

  assign q_ready   = !out_valid_r || out_ch.ready;
  assign pop       = q_word.valid && q_ready;
  assign scale_eff = (scale_r == '0) ? 8'd1 : scale_r;
  assign start     = (phase_r == PH_IDLE) && q_word.item.go;

  // a go request seen in idle takes effect within the same tick
  assign e_phase = start ? PH_START_A : phase_r;
  assign e_dc    = start ? dly_load(PH_START_A, scale_eff) : dc_r;
  assign e_wt    = start ? '0 : wt_r;
  assign e_bc    = start ? '0 : bc_r;
  assign e_sh    = start ? '0 : sh_r;
  assign e_st    = start ? STG_ADDR : st_r;
  assign e_err   = start ? ERR_NONE : err_r;
  assign e_mode  = start ? q_word.item.mode : mode_r;
  assign e_dev   = start ? q_word.item.dev_addr : dev_r;
  assign e_reg   = start ? q_word.item.reg_addr : reg_r;
  assign e_wdat  = start ? q_word.item.wdata : wdat_r;

  assign dc_dec = (e_dc != '0) ? e_dc - 1'b1 : e_dc;
  assign bc_inc = e_bc + 1'b1;

  always_comb begin
    sda_ctl                 = seg_sda(e_phase);
    res_nxt.scl_level       = seg_scl(e_phase);
    res_nxt.sda_drive_low   = (sda_ctl == SDA_LOW) ||
                              ((sda_ctl == SDA_DATA) && !e_sh[MSB]);
    res_nxt.busy_res        = (e_phase != PH_IDLE) && (e_phase != PH_FINISH);
    res_nxt.done_res        = (e_phase == PH_FINISH);
    res_nxt.read_byte       = (res_nxt.done_res && e_mode) ? e_sh : 8'd0;
    res_nxt.error_code      = res_nxt.done_res ? e_err : ERR_NONE;
  end

  always_comb begin
    phase_nxt = e_phase;
    dc_nxt    = e_dc;
    wt_nxt    = e_wt;
    bc_nxt    = e_bc;
    sh_nxt    = e_sh;
    st_nxt    = e_st;
    err_nxt   = e_err;
    do_enter  = 1'b0;
    ent_ph    = e_phase;
    seg_done  = 1'b0;
    ack_done  = 1'b0;
    ack_tmo   = 1'b0;

    case (e_phase)
      PH_IDLE: begin
      end
      PH_FINISH: begin
        do_enter = 1'b1;
        ent_ph   = PH_IDLE;
      end
      PH_ACK_POLL: begin
        if (!q_word.item.sda_in) begin
          ack_done = 1'b1;
        end else if (e_wt == ack_to_r) begin
          ack_done = 1'b1;
          ack_tmo  = 1'b1;
        end else begin
          wt_nxt = e_wt + 1'b1;
        end
      end
      default: begin
        dc_nxt   = dc_dec;
        seg_done = (dc_dec == '0);
      end
    endcase

    if (seg_done) begin
      do_enter = 1'b1;
      case (e_phase)
        PH_START_A:   ent_ph = PH_START_B;
        PH_START_B: begin
          sh_nxt = {e_dev, e_st == STG_LAST};
          bc_nxt = '0;
          ent_ph = PH_BIT_SETUP;
        end
        PH_BIT_SETUP: ent_ph = PH_BIT_HIGH;
        PH_BIT_HIGH:  ent_ph = PH_BIT_LOW;
        PH_BIT_LOW: begin
          sh_nxt = {e_sh[MSB-1:0], 1'b0};
          bc_nxt = bc_inc;
          ent_ph = (bc_inc >= BYTE_BITS) ? PH_ACK_SETUP : PH_BIT_SETUP;
        end
        PH_ACK_SETUP: ent_ph = PH_ACK_HIGH;
        PH_ACK_HIGH:  ent_ph = PH_ACK_POLL;
        PH_RD_LOW:    ent_ph = PH_RD_HIGH;
        PH_RD_HIGH: begin
          sh_nxt = {e_sh[MSB-1:0], q_word.item.sda_in};
          bc_nxt = bc_inc;
          ent_ph = (bc_inc >= BYTE_BITS) ? PH_NACK_LOW : PH_RD_LOW;
        end
        PH_NACK_LOW:  ent_ph = PH_NACK_HIGH;
        PH_NACK_HIGH: ent_ph = PH_STOP_A;
        PH_STOP_A:    ent_ph = PH_STOP_B;
        PH_STOP_B:    ent_ph = PH_FINISH;
        default:      ent_ph = PH_IDLE;
      endcase
    end

    if (ack_done) begin
      do_enter = 1'b1;
      if (!e_mode) begin
        case (e_st)
          STG_ADDR: begin
            if (ack_tmo) begin
              err_nxt = ERR_ADDR;
              ent_ph  = PH_STOP_A;
            end else begin
              st_nxt = STG_REG;
              sh_nxt = e_reg;
              bc_nxt = '0;
              ent_ph = PH_BIT_SETUP;
            end
          end
          STG_REG: begin
            if (ack_tmo && (e_err == ERR_NONE)) err_nxt = ERR_DATA;
            st_nxt = STG_LAST;
            sh_nxt = e_wdat;
            bc_nxt = '0;
            ent_ph = PH_BIT_SETUP;
          end
          default: begin
            if (ack_tmo) err_nxt = ERR_DATA;
            ent_ph = PH_STOP_A;
          end
        endcase
      end else begin
        case (e_st)
          STG_ADDR: begin
            if (ack_tmo && (e_err == ERR_NONE)) err_nxt = ERR_ADDR;
            st_nxt = STG_REG;
            sh_nxt = e_reg;
            bc_nxt = '0;
            ent_ph = PH_BIT_SETUP;
          end
          STG_REG: begin
            if (ack_tmo && (e_err == ERR_NONE)) err_nxt = ERR_DATA;
            st_nxt = STG_LAST;
            ent_ph = PH_START_A;
          end
          default: begin
            if (ack_tmo && (e_err == ERR_NONE)) err_nxt = ERR_ADDR;
            sh_nxt = '0;
            bc_nxt = '0;
            ent_ph = PH_RD_LOW;
          end
        endcase
      end
    end

    if (do_enter) begin
      phase_nxt = ent_ph;
      dc_nxt    = dly_load(ent_ph, scale_eff);
      wt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_to_r <= ACK_TIMEOUT_RESET;
      scale_r  <= TICK_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ACK_TIMEOUT: ack_to_r <= cfg_wdata;
        CFG_TICK_SCALE:  scale_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      dc_r    <= '0;
      wt_r    <= '0;
      bc_r    <= '0;
      sh_r    <= '0;
      st_r    <= STG_ADDR;
      err_r   <= ERR_NONE;
      mode_r  <= 1'b0;
      dev_r   <= '0;
      reg_r   <= '0;
      wdat_r  <= '0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      dc_r    <= dc_nxt;
      wt_r    <= wt_nxt;
      bc_r    <= bc_nxt;
      sh_r    <= sh_nxt;
      st_r    <= st_nxt;
      err_r   <= err_nxt;
      mode_r  <= e_mode;
      dev_r   <= e_dev;
      reg_r   <= e_reg;
      wdat_r  <= e_wdat;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.scl_level     = res_r.scl_level;
  assign out_ch.sda_drive_low = res_r.sda_drive_low;
  assign out_ch.busy_res      = res_r.busy_res;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.read_byte     = res_r.read_byte;
  assign out_ch.error_code    = res_r.error_code;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

import i2cra_pkg::*;

class bus_tick_board;
  phase_t     ph;
  stage_t     stg;
  logic [3:0] nbits;
  logic [7:0] shreg;
  logic [15:0] dly;
  logic [7:0] polls;
  logic       cmd_read;
  logic [6:0] cmd_dev;
  logic [7:0] cmd_reg;
  logic [7:0] cmd_wdata;
  err_t       err;
  logic [7:0] ack_limit;
  logic [7:0] scale;
  res_t       pending_ticks[$];
  int         errors;

  function new();
    ack_limit = ACK_TIMEOUT_RESET;
    scale = TICK_SCALE_RESET;
    ph = PH_IDLE;
    stg = STG_ADDR;
    nbits = 0;
    shreg = 0;
    dly = 0;
    polls = 0;
    cmd_read = 0;
    cmd_dev = 0;
    cmd_reg = 0;
    cmd_wdata = 0;
    err = ERR_NONE;
    errors = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
    case (idx)
      CFG_ACK_TIMEOUT: ack_limit = v;
      CFG_TICK_SCALE:  scale = v;
      default: ;
    endcase
  endfunction

  // length of a bus phase in ticks
  function logic [15:0] phase_len(phase_t p);
    logic [2:0] u;
    case (p)
      PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B: u = 3'd4;
      PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW, PH_RD_LOW,
      PH_NACK_LOW, PH_NACK_HIGH:                    u = 3'd2;
      PH_ACK_SETUP, PH_ACK_HIGH, PH_RD_HIGH:        u = 3'd1;
      default:                                      u = 3'd0;
    endcase
    return 16'(u) * 16'((scale == 8'd0) ? 8'd1 : scale);
  endfunction

  function void goto(phase_t p);
    ph = p;
    dly = phase_len(p);
    polls = 0;
  endfunction

  function void load(logic [7:0] v);
    shreg = v;
    nbits = 0;
    goto(PH_BIT_SETUP);
  endfunction

  function void ack_seen(bit late);
    if (!cmd_read) begin
      case (stg)
        STG_ADDR: begin
          if (late) begin
            err = ERR_ADDR;
            goto(PH_STOP_A);
          end else begin
            stg = STG_REG;
            load(cmd_reg);
          end
        end
        STG_REG: begin
          // register nack is noted but the write goes on
          if (late && err == ERR_NONE) err = ERR_DATA;
          stg = STG_LAST;
          load(cmd_wdata);
        end
        default: begin
          if (late) err = ERR_DATA;
          goto(PH_STOP_A);
        end
      endcase
    end else begin
      case (stg)
        STG_ADDR: begin
          if (late && err == ERR_NONE) err = ERR_ADDR;
          stg = STG_REG;
          load(cmd_reg);
        end
        STG_REG: begin
          if (late && err == ERR_NONE) err = ERR_DATA;
          stg = STG_LAST;
          goto(PH_START_A);
        end
        default: begin
          if (late && err == ERR_NONE) err = ERR_ADDR;
          shreg = 0;
          nbits = 0;
          goto(PH_RD_LOW);
        end
      endcase
    end
  endfunction

  function void seg_done(logic s);
    case (ph)
      PH_START_A:   goto(PH_START_B);
      PH_START_B:   load({cmd_dev, stg == STG_LAST});
      PH_BIT_SETUP: goto(PH_BIT_HIGH);
      PH_BIT_HIGH:  goto(PH_BIT_LOW);
      PH_BIT_LOW: begin
        shreg = shreg << 1;
        nbits = nbits + 1'b1;
        goto((nbits >= BYTE_BITS) ? PH_ACK_SETUP : PH_BIT_SETUP);
      end
      PH_ACK_SETUP: goto(PH_ACK_HIGH);
      PH_ACK_HIGH:  goto(PH_ACK_POLL);
      PH_RD_LOW:    goto(PH_RD_HIGH);
      PH_RD_HIGH: begin
        shreg = {shreg[6:0], s};
        nbits = nbits + 1'b1;
        goto((nbits >= BYTE_BITS) ? PH_NACK_LOW : PH_RD_LOW);
      end
      PH_NACK_LOW:  goto(PH_NACK_HIGH);
      PH_NACK_HIGH: goto(PH_STOP_A);
      PH_STOP_A:    goto(PH_STOP_B);
      PH_STOP_B:    goto(PH_FINISH);
      default:      goto(PH_IDLE);
    endcase
  endfunction

  function res_t advance_bus(item_t w);
    res_t   r;
    phase_t p;
    if (ph == PH_IDLE && w.go) begin
      cmd_read = w.mode;
      cmd_dev = w.dev_addr;
      cmd_reg = w.reg_addr;
      cmd_wdata = w.wdata;
      err = ERR_NONE;
      stg = STG_ADDR;
      nbits = 0;
      shreg = 0;
      goto(PH_START_A);
    end
    p = ph;
    case (p)
      PH_BIT_SETUP, PH_BIT_LOW, PH_ACK_SETUP, PH_RD_LOW,
      PH_NACK_LOW, PH_STOP_A: r.scl_level = 1'b0;
      default:                r.scl_level = 1'b1;
    endcase
    case (p)
      PH_START_B, PH_STOP_A, PH_STOP_B:      r.sda_drive_low = 1'b1;
      PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW: r.sda_drive_low = !shreg[7];
      default:                               r.sda_drive_low = 1'b0;
    endcase
    r.busy_res = (p != PH_IDLE) && (p != PH_FINISH);
    r.done_res = (p == PH_FINISH);
    r.read_byte = (p == PH_FINISH && cmd_read) ? shreg : 8'd0;
    r.error_code = (p == PH_FINISH) ? err : ERR_NONE;

    if (p == PH_FINISH) begin
      goto(PH_IDLE);
    end else if (p == PH_ACK_POLL) begin
      if (!w.sda_in) ack_seen(1'b0);
      else if (polls == ack_limit) ack_seen(1'b1);
      else polls = polls + 1'b1;
    end else if (p != PH_IDLE) begin
      if (dly > 0) dly = dly - 1'b1;
      if (dly == 0) seg_done(w.sda_in);
    end
    return r;
  endfunction

  function void note_word(item_t w);
    pending_ticks.push_back(advance_bus(w));
  endfunction

  function void cmp(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_word(res_t got);
    res_t want;
    if (pending_ticks.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    want = pending_ticks.pop_front();
    cmp("scl_level", want.scl_level, got.scl_level);
    cmp("sda_drive_low", want.sda_drive_low, got.sda_drive_low);
    cmp("busy_res", want.busy_res, got.busy_res);
    cmp("done_res", want.done_res, got.done_res);
    cmp("read_byte", want.read_byte, got.read_byte);
    cmp("error_code", want.error_code, got.error_code);
  endfunction
endclass

module tb;
  localparam int ItemW = $bits(item_t);

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2cra_in_if  in_ch();
  i2cra_out_if out_ch();

  i2c_register_access_master DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  bus_tick_board board;
  int burst_left;
  int hold_req;
  int hold_left;
  int rx_tick;
  int rx_style;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern plus long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req - 1;
      hold_req = 0;
      out_ch.ready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 256 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= 1'($urandom_range(0, 1));
        2:       out_ch.ready <= (rx_tick % 4) != 0;
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : mon
    item_t w;
    res_t  got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready === 1'b1) begin
        w.go = in_ch.go;
        w.mode = in_ch.mode;
        w.dev_addr = in_ch.dev_addr;
        w.reg_addr = in_ch.reg_addr;
        w.wdata = in_ch.wdata;
        w.sda_in = in_ch.sda_in;
        board.note_word(w);
      end
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        got.scl_level = out_ch.scl_level;
        got.sda_drive_low = out_ch.sda_drive_low;
        got.busy_res = out_ch.busy_res;
        got.done_res = out_ch.done_res;
        got.read_byte = out_ch.read_byte;
        got.error_code = err_t'(out_ch.error_code);
        board.check_word(got);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task send_word(input item_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.go <= w.go;
    in_ch.mode <= w.mode;
    in_ch.dev_addr <= w.dev_addr;
    in_ch.reg_addr <= w.reg_addr;
    in_ch.wdata <= w.wdata;
    in_ch.sda_in <= w.sda_in;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task idle_ticks(input int n);
    item_t w;
    repeat (n) begin
      w = ItemW'($urandom);
      w.go = 1'b0;
      send_word(w);
    end
  endtask

  // one transaction from go to done; nack_mask picks the acks that time out
  task run_txn(input bit rd, input logic [6:0] dev, input logic [7:0] ra,
               input logic [7:0] wd, input logic [2:0] nack_mask,
               input logic [7:0] rx_byte);
    item_t w;
    bit    started;
    started = 1'b0;
    forever begin
      w = ItemW'($urandom);
      if (board.ph == PH_IDLE) begin
        if (started) break;
        w.go = 1'b1;
        w.mode = rd;
        w.dev_addr = dev;
        w.reg_addr = ra;
        w.wdata = wd;
        started = 1'b1;
      end else begin
        // stray go while busy
        w.go = ($urandom_range(0, 7) == 0);
        case (board.ph)
          PH_ACK_POLL: begin
            if (nack_mask[board.stg]) w.sda_in = 1'b1;
            else w.sda_in = !(board.polls == board.ack_limit || $urandom_range(0, 2) == 0);
          end
          PH_RD_HIGH: w.sda_in = rx_byte[7 - int'(board.nbits)];
          default: ;
        endcase
      end
      send_word(w);
    end
  endtask

  task random_txns(input int n, input int nack_odds);
    logic [2:0] mask;
    repeat (n) begin
      mask[0] = ($urandom_range(1, nack_odds) == 1);
      mask[1] = ($urandom_range(1, nack_odds) == 1);
      mask[2] = ($urandom_range(1, nack_odds) == 1);
      run_txn(1'($urandom_range(0, 1)), 7'($urandom), 8'($urandom), 8'($urandom), mask,
              8'($urandom));
      idle_ticks($urandom_range(0, 4));
    end
  endtask

  // sender pause until every expected word is back
  task settle;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.pending_ticks.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, v);
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.go = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.dev_addr = '0;
    in_ch.reg_addr = '0;
    in_ch.wdata = '0;
    in_ch.sda_in = 1'b0;
    out_ch.ready = 1'b0;
    burst_left = 0;
    hold_req = 0;
    hold_left = 0;
    rx_tick = 0;
    rx_style = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset register values
    run_txn(1'b0, 7'h2a, 8'h55, 8'haa, 3'b000, 8'h00);
    idle_ticks(3);

    settle();
    write_reg(CFG_ACK_TIMEOUT, 8'd2);
    write_reg(CFG_TICK_SCALE, 8'd1);
    hold_req = 80;
    run_txn(1'b1, 7'h55, 8'h0f, 8'h33, 3'b111, 8'ha5);
    run_txn(1'b0, 7'h15, 8'haa, 8'h55, 3'b001, 8'h00);

    settle();
    random_txns(1, 3);

    settle();
    write_reg(CFG_ACK_TIMEOUT, 8'd1);
    write_reg(CFG_TICK_SCALE, 8'd2);
    run_txn(1'b0, 7'h7f, 8'hff, 8'hff, 3'b001, 8'h00);
    idle_ticks(2);

    settle();
    if (board.errors == 0 && board.pending_ticks.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb: errors");
    $finish;
  end
endmodule
